/* rtl/core/psd_pkg.sv */
// psd_pkg: types and widths shared by the point to segment signed distance unit
// no dependencies; used by every module under rtl/core
package psd_pkg;

    // coordinate and derived widths
    localparam int COORD_W = 20;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int DOT_W   = PROD_W + 2;
    localparam int HALF_W  = SUM_W / 2;
    localparam int NUM_W   = 2 * SUM_W;
    localparam int REM_W   = HALF_W + 2;
    localparam int DIST_W  = 22;

    // where the projection lands
    typedef enum logic [1:0] {
        REGION_WITHIN = 2'd0,
        REGION_BEFORE = 2'd1,
        REGION_PAST   = 2'd2
    } region_t;

    // input word
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_start_z;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        logic signed [COORD_W-1:0] seg_end_z;
    } in_t;

    // result word
    typedef struct packed {
        logic signed [DIST_W-1:0] signed_distance;
        region_t                  region;
        logic                     degenerate;
    } out_t;

    // classification carried alongside the arithmetic
    typedef struct packed {
        region_t            region;
        logic               degenerate;
        logic [SUM_W-1:0]   alt;
        logic [SUM_W-1:0]   t2;
    } side_t;

    // front end to divider
    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [SUM_W-1:0]   divisor;
        side_t              side;
    } div_word_t;

    // divider to root unit
    typedef struct packed {
        logic [SUM_W-1:0]   radicand;
        region_t            region;
        logic               degenerate;
    } root_word_t;

endpackage

/* rtl/core/psd_front.sv */
// psd_front: differences, squared lengths, dot product, region and dot squared
// depends on psd_pkg; feeds psd_div
module psd_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    item_valid,
    input  psd_pkg::in_t            item,
    output logic                    div_valid,
    output psd_pkg::div_word_t      div_word
);

    logic [5:0] vld_reg;
    logic [5:0] vld_next;

    // stage 1: differences
    logic signed [psd_pkg::COORD_W-1:0] p [3];
    logic signed [psd_pkg::COORD_W-1:0] s [3];
    logic signed [psd_pkg::COORD_W-1:0] e [3];
    logic signed [psd_pkg::DIFF_W-1:0]  to_reg [3];
    logic signed [psd_pkg::DIFF_W-1:0]  dir_reg [3];
    logic signed [psd_pkg::DIFF_W-1:0]  toend_reg [3];
    logic signed [psd_pkg::DIFF_W-1:0]  to_next [3];
    logic signed [psd_pkg::DIFF_W-1:0]  dir_next [3];
    logic signed [psd_pkg::DIFF_W-1:0]  toend_next [3];

    // stage 2: products
    logic signed [psd_pkg::PROD_W-1:0]  pt [3];
    logic signed [psd_pkg::PROD_W-1:0]  pl [3];
    logic signed [psd_pkg::PROD_W-1:0]  pe [3];
    logic signed [psd_pkg::PROD_W-1:0]  prd_next [3];
    logic [psd_pkg::SQ_W-1:0]           sqt_reg [3];
    logic [psd_pkg::SQ_W-1:0]           sql_reg [3];
    logic [psd_pkg::SQ_W-1:0]           sqe_reg [3];
    logic signed [psd_pkg::PROD_W-1:0]  prd_reg [3];

    // stage 3: sums
    logic [psd_pkg::SUM_W-1:0]          t2_reg, l2_reg, e2_reg;
    logic [psd_pkg::SUM_W-1:0]          t2_next, l2_next, e2_next;
    logic signed [psd_pkg::DOT_W-1:0]   dot_reg, dot_next;

    // stage 4: classification
    logic                               is_before, past, degen;
    psd_pkg::side_t                     side4_reg, side4_next;
    logic [psd_pkg::SUM_W-1:0]          dsel_reg, dsel_next;
    logic [psd_pkg::SUM_W-1:0]          lm1_reg, lm1_next;
    logic [psd_pkg::SUM_W-1:0]          l2b_reg;

    // stage 5: partial products of dot squared
    logic [psd_pkg::SUM_W-1:0]          hh_reg, hl_reg, ll_reg;
    logic [psd_pkg::SUM_W-1:0]          hh_next, hl_next, ll_next;
    logic [psd_pkg::SUM_W-1:0]          lm1b_reg, l2c_reg;
    psd_pkg::side_t                     side5_reg;

    // stage 6: dividend
    psd_pkg::div_word_t                 word_reg, word_next;

    assign vld_next = {vld_reg[4:0], item_valid};

    // coordinate unpack and differences
    always_comb
    begin
        p[0] = item.point_x;
        p[1] = item.point_y;
        p[2] = item.point_z;
        s[0] = item.seg_start_x;
        s[1] = item.seg_start_y;
        s[2] = item.seg_start_z;
        e[0] = item.seg_end_x;
        e[1] = item.seg_end_y;
        e[2] = item.seg_end_z;
        for (int k = 0; k < 3; k++)
        begin
            to_next[k]    = psd_pkg::DIFF_W'(p[k]) - psd_pkg::DIFF_W'(s[k]);
            dir_next[k]   = psd_pkg::DIFF_W'(e[k]) - psd_pkg::DIFF_W'(s[k]);
            toend_next[k] = psd_pkg::DIFF_W'(p[k]) - psd_pkg::DIFF_W'(e[k]);
        end
    end

    // squares and dot terms
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pt[k]       = to_reg[k] * to_reg[k];
            pl[k]       = dir_reg[k] * dir_reg[k];
            pe[k]       = toend_reg[k] * toend_reg[k];
            prd_next[k] = to_reg[k] * dir_reg[k];
        end
    end

    // sums of three
    always_comb
    begin
        t2_next  = {2'b00, sqt_reg[0]} + {2'b00, sqt_reg[1]} + {2'b00, sqt_reg[2]};
        l2_next  = {2'b00, sql_reg[0]} + {2'b00, sql_reg[1]} + {2'b00, sql_reg[2]};
        e2_next  = {2'b00, sqe_reg[0]} + {2'b00, sqe_reg[1]} + {2'b00, sqe_reg[2]};
        dot_next = psd_pkg::DOT_W'(prd_reg[0]) + psd_pkg::DOT_W'(prd_reg[1])
                 + psd_pkg::DOT_W'(prd_reg[2]);
    end

    // region decision and dividend terms
    always_comb
    begin
        degen     = (l2_reg == '0);
        is_before = dot_reg[psd_pkg::DOT_W-1];
        past      = !is_before && (dot_reg > $signed({2'b00, l2_reg}));
        side4_next.degenerate = degen;
        side4_next.t2         = t2_reg;
        side4_next.alt        = past ? e2_reg : t2_reg;
        if (degen)
            side4_next.region = psd_pkg::REGION_WITHIN;
        else if (is_before)
            side4_next.region = psd_pkg::REGION_BEFORE;
        else if (past)
            side4_next.region = psd_pkg::REGION_PAST;
        else
            side4_next.region = psd_pkg::REGION_WITHIN;
        dsel_next = (!degen && !is_before && !past) ? dot_reg[psd_pkg::SUM_W-1:0] : '0;
        lm1_next  = degen ? '0 : l2_reg - psd_pkg::SUM_W'(1);
    end

    // dot squared split in halves
    always_comb
    begin
        hh_next = dsel_reg[psd_pkg::SUM_W-1:psd_pkg::HALF_W]
                * dsel_reg[psd_pkg::SUM_W-1:psd_pkg::HALF_W];
        hl_next = dsel_reg[psd_pkg::SUM_W-1:psd_pkg::HALF_W]
                * dsel_reg[psd_pkg::HALF_W-1:0];
        ll_next = dsel_reg[psd_pkg::HALF_W-1:0] * dsel_reg[psd_pkg::HALF_W-1:0];
    end

    // dividend is dot squared plus divisor minus one, for a rounded up quotient; dot is zeroed outside the segment
    always_comb
    begin
        word_next.num = {hh_reg, {psd_pkg::SUM_W{1'b0}}}
                      + psd_pkg::NUM_W'({hl_reg, {(psd_pkg::HALF_W + 1){1'b0}}})
                      + psd_pkg::NUM_W'(ll_reg)
                      + psd_pkg::NUM_W'(lm1b_reg);
        word_next.divisor = l2c_reg;
        word_next.side    = side5_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                to_reg[k]    <= to_next[k];
                dir_reg[k]   <= dir_next[k];
                toend_reg[k] <= toend_next[k];
                sqt_reg[k]   <= pt[k][psd_pkg::SQ_W-1:0];
                sql_reg[k]   <= pl[k][psd_pkg::SQ_W-1:0];
                sqe_reg[k]   <= pe[k][psd_pkg::SQ_W-1:0];
                prd_reg[k]   <= prd_next[k];
            end
            t2_reg    <= t2_next;
            l2_reg    <= l2_next;
            e2_reg    <= e2_next;
            dot_reg   <= dot_next;
            side4_reg <= side4_next;
            dsel_reg  <= dsel_next;
            lm1_reg   <= lm1_next;
            l2b_reg   <= l2_reg;
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            ll_reg    <= ll_next;
            lm1b_reg  <= lm1_reg;
            l2c_reg   <= l2b_reg;
            side5_reg <= side4_reg;
            word_reg  <= word_next;
        end
    end

    assign div_valid = vld_reg[5];
    assign div_word  = word_reg;

endmodule

/* rtl/core/psd_div.sv */
// psd_div: pipelined restoring divider, one quotient bit per stage
// depends on psd_pkg; fed by psd_front, feeds psd_root
module psd_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    div_valid,
    input  psd_pkg::div_word_t      div_word,
    output logic                    root_valid,
    output psd_pkg::root_word_t     root_word
);

    localparam int NSTEP = psd_pkg::SUM_W;

    logic [NSTEP-1:0]           vld_reg, vld_next;
    logic [psd_pkg::SUM_W-1:0]  rem_reg [NSTEP];
    logic [psd_pkg::SUM_W-1:0]  low_reg [NSTEP];
    logic [psd_pkg::SUM_W-1:0]  quo_reg [NSTEP];
    logic [psd_pkg::SUM_W-1:0]  dvs_reg [NSTEP];
    psd_pkg::side_t             side_reg [NSTEP];
    logic [psd_pkg::SUM_W-1:0]  rem_next [NSTEP];
    logic [psd_pkg::SUM_W-1:0]  low_next [NSTEP];
    logic [psd_pkg::SUM_W-1:0]  quo_next [NSTEP];
    logic [psd_pkg::SUM_W-1:0]  dvs_next [NSTEP];
    psd_pkg::side_t             side_next [NSTEP];
    logic                       rv_reg;
    psd_pkg::root_word_t        rw_reg, rw_next;
    psd_pkg::side_t             last_side;

    assign vld_next = {vld_reg[NSTEP-2:0], div_valid};

    // one compare and subtract per stage
    always_comb
    begin
        logic [psd_pkg::SUM_W-1:0] r;
        logic [psd_pkg::SUM_W-1:0] lo;
        logic [psd_pkg::SUM_W-1:0] q;
        logic [psd_pkg::SUM_W-1:0] d;
        logic [psd_pkg::SUM_W:0]   tmp;
        logic                      ge;
        for (int i = 0; i < NSTEP; i++)
        begin
            if (i == 0)
            begin
                r  = div_word.num[psd_pkg::NUM_W-1:psd_pkg::SUM_W];
                lo = div_word.num[psd_pkg::SUM_W-1:0];
                q  = '0;
                d  = div_word.divisor;
                side_next[i] = div_word.side;
            end
            else
            begin
                r  = rem_reg[i-1];
                lo = low_reg[i-1];
                q  = quo_reg[i-1];
                d  = dvs_reg[i-1];
                side_next[i] = side_reg[i-1];
            end
            tmp = {r, lo[psd_pkg::SUM_W-1]};
            ge  = (tmp >= {1'b0, d});
            rem_next[i] = ge ? psd_pkg::SUM_W'(tmp - {1'b0, d}) : tmp[psd_pkg::SUM_W-1:0];
            low_next[i] = {lo[psd_pkg::SUM_W-2:0], 1'b0};
            quo_next[i] = {q[psd_pkg::SUM_W-2:0], ge};
            dvs_next[i] = d;
        end
    end

    // squared perpendicular distance, or the end point distance outside
    always_comb
    begin
        last_side = side_reg[NSTEP-1];
        rw_next.region     = last_side.region;
        rw_next.degenerate = last_side.degenerate;
        if (last_side.region == psd_pkg::REGION_WITHIN)
            rw_next.radicand = last_side.t2 - quo_reg[NSTEP-1];
        else
            rw_next.radicand = last_side.alt;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rv_reg  <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
            rv_reg  <= vld_reg[NSTEP-1];
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NSTEP; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                low_reg[i]  <= low_next[i];
                quo_reg[i]  <= quo_next[i];
                dvs_reg[i]  <= dvs_next[i];
                side_reg[i] <= side_next[i];
            end
            rw_reg <= rw_next;
        end
    end

    assign root_valid = rv_reg;
    assign root_word  = rw_reg;

endmodule

/* rtl/core/psd_root.sv */
// psd_root: pipelined truncated square root, one root bit per stage, and result register
// depends on psd_pkg; fed by psd_div
module psd_root (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    root_valid,
    input  psd_pkg::root_word_t     root_word,
    output logic                    result_valid,
    output psd_pkg::out_t           result
);

    localparam int NSTEP = psd_pkg::HALF_W;
    localparam int TMP_W = psd_pkg::REM_W + 2;

    logic [NSTEP-1:0]            vld_reg, vld_next;
    logic [psd_pkg::REM_W-1:0]   rem_reg [NSTEP];
    logic [psd_pkg::HALF_W-1:0]  rt_reg [NSTEP];
    logic [psd_pkg::SUM_W-1:0]   x_reg [NSTEP];
    psd_pkg::region_t            reg_reg [NSTEP];
    logic                        dg_reg [NSTEP];
    logic [psd_pkg::REM_W-1:0]   rem_next [NSTEP];
    logic [psd_pkg::HALF_W-1:0]  rt_next [NSTEP];
    logic [psd_pkg::SUM_W-1:0]   x_next [NSTEP];
    psd_pkg::region_t            reg_next [NSTEP];
    logic                        dg_next [NSTEP];
    logic                        out_valid_reg;
    psd_pkg::out_t               out_reg, out_next;
    logic [psd_pkg::DIST_W-1:0]  mag;

    assign vld_next = {vld_reg[NSTEP-2:0], root_valid};

    // two radicand bits per stage
    always_comb
    begin
        logic [psd_pkg::REM_W-1:0]  r;
        logic [psd_pkg::HALF_W-1:0] rt;
        logic [psd_pkg::SUM_W-1:0]  x;
        logic [TMP_W-1:0]           tmp;
        logic [TMP_W-1:0]           trial;
        logic                       ge;
        for (int i = 0; i < NSTEP; i++)
        begin
            if (i == 0)
            begin
                r  = '0;
                rt = '0;
                x  = root_word.radicand;
                reg_next[i] = root_word.region;
                dg_next[i]  = root_word.degenerate;
            end
            else
            begin
                r  = rem_reg[i-1];
                rt = rt_reg[i-1];
                x  = x_reg[i-1];
                reg_next[i] = reg_reg[i-1];
                dg_next[i]  = dg_reg[i-1];
            end
            tmp   = {r, x[psd_pkg::SUM_W-1:psd_pkg::SUM_W-2]};
            trial = TMP_W'({rt, 2'b01});
            ge    = (tmp >= trial);
            rem_next[i] = ge ? psd_pkg::REM_W'(tmp - trial) : psd_pkg::REM_W'(tmp);
            rt_next[i]  = {rt[psd_pkg::HALF_W-2:0], ge};
            x_next[i]   = {x[psd_pkg::SUM_W-3:0], 2'b00};
        end
    end

    // sign and zero-length override
    always_comb
    begin
        mag = psd_pkg::DIST_W'(rt_reg[NSTEP-1]);
        out_next.region     = reg_reg[NSTEP-1];
        out_next.degenerate = dg_reg[NSTEP-1];
        if (dg_reg[NSTEP-1])
            out_next.signed_distance = '0;
        else if (reg_reg[NSTEP-1] == psd_pkg::REGION_WITHIN)
            out_next.signed_distance = mag;
        else
            out_next.signed_distance = psd_pkg::DIST_W'(0) - mag;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= vld_reg[NSTEP-1];
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NSTEP; i++)
            begin
                rem_reg[i] <= rem_next[i];
                rt_reg[i]  <= rt_next[i];
                x_reg[i]   <= x_next[i];
                reg_reg[i] <= reg_next[i];
                dg_reg[i]  <= dg_next[i];
            end
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* rtl/core/point_segment_signed_distance_unit.sv */
// point_segment_signed_distance_unit: top level of the signed distance pipeline
// depends on psd_pkg, psd_front, psd_div, psd_root
//
// Usage: one input word holds a point and the start and end of a segment,
// signed with 4 fraction bits. One result word per input word gives the
// truncated distance: positive perpendicular distance when the projection
// lands on the segment, minus the distance to the start or end otherwise,
// with the region code and a zero-length flag (distance then 0).
// Channels: item/item_valid/item_stall in, result/result_valid/result_stall out.
// A word passes 71 registers, the first loaded at the accepting edge (6 front
// end stages, 42 divider stages plus one, 21 root stages plus the result
// register). Throughput: one word per cycle while result_stall does not hold
// the pipeline; set by the fully pipelined divider and root.
// Reset clears all valid bits; no word is in flight afterward.
// When the receiver stalls a valid result, the whole pipeline holds and
// item_stall rises in the same cycle; an empty result register never stalls.
module point_segment_signed_distance_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  psd_pkg::in_t    item,
    output logic            result_valid,
    input  logic            result_stall,
    output psd_pkg::out_t   result
);

    logic                   adv;
    logic                   div_valid;
    psd_pkg::div_word_t     div_word;
    logic                   root_valid;
    psd_pkg::root_word_t    root_word;

    // global advance: hold everything while a result waits
    assign adv        = !result_valid || !result_stall;
    assign item_stall = !adv;

    psd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item),
        .div_valid  (div_valid),
        .div_word   (div_word)
    );

    psd_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .div_valid  (div_valid),
        .div_word   (div_word),
        .root_valid (root_valid),
        .root_word  (root_word)
    );

    psd_root u_root (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .root_valid   (root_valid),
        .root_word    (root_word),
        .result_valid (result_valid),
        .result       (result)
    );

    // zero-length segment gives zero distance inside
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |->
            result.signed_distance == '0 && result.region == psd_pkg::REGION_WITHIN)
        else $error("degenerate word with nonzero distance");

    // inside the segment the distance is never negative
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.region == psd_pkg::REGION_WITHIN |->
            !result.signed_distance[psd_pkg::DIST_W-1])
        else $error("negative distance inside segment");

    // outside the segment the distance is never positive
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.region != psd_pkg::REGION_WITHIN |->
            result.signed_distance[psd_pkg::DIST_W-1] || result.signed_distance == '0)
        else $error("positive distance outside segment");

    // a stalled pipeline keeps the valid bits that feed the divider and the root unit
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(div_valid) && $stable(root_valid))
        else $error("pipeline moved while stalled");

endmodule
